// File: rtl/dpc_pkg.sv
// dpc_pkg: shared types, phase codes, register indexes and time-of-day helpers
// for the daylight phase classifier; no dependencies

package dpc_pkg;

   // register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUNRISE_HOUR   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUNRISE_MINUTE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUNSET_HOUR    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUNSET_MINUTE  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RAMP_MINUTES   = 3'd4;
   localparam int CSR_DATA_WIDTH = 6;

   // phase codes
   localparam logic [2:0] PHASE_NIGHT       = 3'd0;
   localparam logic [2:0] PHASE_DAY         = 3'd1;
   localparam logic [2:0] PHASE_RISE_START  = 3'd2;
   localparam logic [2:0] PHASE_RISE_RAMP   = 3'd3;
   localparam logic [2:0] PHASE_SET_START   = 3'd4;
   localparam logic [2:0] PHASE_SET_RAMP    = 3'd5;

   localparam logic [5:0] RAMP_MAX = 6'd59;

   typedef struct packed {
      logic [4:0] h;
      logic [5:0] m;
   } tod_type;

   typedef struct packed {
      logic [4:0] now_hour;
      logic [5:0] now_minute;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [5:0] minutes_elapsed;
   } rsp_payload_type;

   typedef struct packed {
      tod_type    rise;
      tod_type    set;
      logic [5:0] ramp;
   } cfg_type;

   // outcome of the window checks, handed to the elapsed-time stage
   typedef struct packed {
      logic       ramp;
      logic       wraps;
      logic [2:0] base_phase;
      tod_type    now;
      tod_type    start;
   } ramp_sel_type;

   // add up to one hour of minutes, one carry each on minute and hour
   function automatic tod_type tod_add(tod_type t, logic [6:0] minutes);
      logic [6:0] add_m;
      logic [1:0] add_h;
      logic [6:0] msum;
      logic [5:0] hsum;
      tod_type    r;
      if (minutes >= 7'd60) begin
         add_h = 2'd1;
         add_m = 7'd0;
      end else begin
         add_h = 2'd0;
         add_m = minutes;
      end
      msum = {1'b0, t.m} + add_m;
      if (msum >= 7'd60) begin
         msum  = msum - 7'd60;
         add_h = add_h + 2'd1;
      end
      hsum = {1'b0, t.h} + {4'd0, add_h};
      if (hsum >= 6'd24) begin
         hsum = hsum - 6'd24;
      end
      r.h = hsum[4:0];
      r.m = msum[5:0];
      return r;
   endfunction

   function automatic logic not_after(tod_type a, tod_type b);
      return (a.h < b.h) || ((a.h == b.h) && (a.m <= b.m));
   endfunction

   function automatic logic in_window(tod_type t, tod_type s, tod_type e);
      logic r;
      if ((t.h < s.h) || (t.h > e.h)) begin
         r = 1'b0;
      end else if (s.h == e.h) begin
         r = (t.m >= s.m) && (t.m < e.m);
      end else if (t.h == s.h) begin
         r = (t.m >= s.m);
      end else if (t.h == e.h) begin
         r = (t.m < e.m);
      end else begin
         r = 1'b1;
      end
      return r;
   endfunction

   // signed minutes since the ramp start, no wrap at 13 bits
   function automatic logic signed [12:0] ramp_elapsed(tod_type now, tod_type start,
                                                       logic wraps);
      logic signed [12:0] nh;
      logic signed [12:0] nm;
      logic signed [12:0] sh;
      logic signed [12:0] sm;
      logic signed [12:0] mid;
      logic signed [12:0] r;
      nh = 13'(now.h);
      nm = 13'(now.m);
      sh = 13'(start.h);
      sm = 13'(start.m);
      mid = (start.h < 5'd23) ? 13'(5'd23 - start.h) : 13'sd0;
      if (now == start) begin
         r = 13'sd0;
      end else if (!wraps) begin
         r = not_after(start, now) ? ((nh - sh) * 13'sd60 + nm - sm) : 13'sd0;
      end else if (not_after(now, start)) begin
         r = nh * 13'sd60 + nm + 13'sd60 - sm + mid * 13'sd60;
      end else begin
         r = (nh - sh) * 13'sd60 + nm - sm;
      end
      return r;
   endfunction

endpackage

// File: rtl/dpc_classify.sv
// dpc_classify: night/day window and sunrise/sunset ramp window checks
// depends on dpc_pkg

module dpc_classify (
   input  dpc_pkg::cfg_type      cfg,
   input  dpc_pkg::tod_type      now,
   output dpc_pkg::ramp_sel_type sel
);
   import dpc_pkg::*;

   tod_type rise_end;
   tod_type night;
   logic    is_day;
   logic    rise_wrap;
   logic    rise_hit;
   logic    set_wrap;
   logic    set_hit;

   assign rise_end = tod_add(cfg.rise, {1'b0, cfg.ramp});
   assign night    = tod_add(cfg.set, {1'b0, cfg.ramp} + 7'd1);

   // day window may cross midnight, then it is the complement of night..rise
   assign is_day = not_after(night, cfg.rise) ? !in_window(now, night, cfg.rise)
                                              : in_window(now, cfg.rise, night);

   assign rise_wrap = not_after(rise_end, cfg.rise);
   assign rise_hit  = rise_wrap ? !in_window(now, rise_end, cfg.rise)
                                : in_window(now, cfg.rise, rise_end);

   assign set_wrap = not_after(night, cfg.set);
   assign set_hit  = set_wrap ? !in_window(now, night, cfg.set)
                              : in_window(now, cfg.set, night);

   always_comb begin
      sel.now        = now;
      sel.ramp       = 1'b0;
      sel.wraps      = 1'b0;
      sel.start      = cfg.rise;
      sel.base_phase = PHASE_NIGHT;
      if (is_day) begin
         if (rise_hit) begin
            sel.ramp       = 1'b1;
            sel.wraps      = rise_wrap;
            sel.base_phase = PHASE_RISE_START;
         end else if (set_hit) begin
            sel.ramp       = 1'b1;
            sel.wraps      = set_wrap;
            sel.start      = cfg.set;
            sel.base_phase = PHASE_SET_START;
         end else begin
            sel.base_phase = PHASE_DAY;
         end
      end
   end

endmodule

// File: rtl/daylight_phase_classifier_core.sv
// daylight_phase_classifier_core: top level, csr registers, three-stage pipeline
// depends on dpc_pkg and dpc_classify

// Classifies a time of day (hour, minute) as night, day, sunrise start, sunrise
// ramp, sunset start or sunset ramp against the programmed sunrise and sunset
// times and ramp length, and returns the minutes since the active ramp began
// (zero outside a ramp, clamped to 59). Windows that cross midnight are taken
// as the complement of the other window. Every item passes three registers:
// the input register, the window-check register and the result register, and
// one item is taken every clock cycle while the result side does not stall;
// stalls on the result side ripple back stage by stage through the ready chain.
// Registers are written through the csr port with no wait; a ramp length above
// 59 is stored as 59, and indexes above the last register are ignored. Write
// the registers only while no item is in flight.

module daylight_phase_classifier_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  dpc_pkg::req_payload_type               req_payload,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output dpc_pkg::rsp_payload_type               rsp_payload,
   // register write port
   input  logic                                   csr_write_en,
   input  logic [dpc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dpc_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import dpc_pkg::*;

   // configuration registers
   logic [4:0] sunrise_hour_ff;
   logic [5:0] sunrise_minute_ff;
   logic [4:0] sunset_hour_ff;
   logic [5:0] sunset_minute_ff;
   logic [5:0] ramp_minutes_ff;
   cfg_type    cfg;

   // pipeline stages
   logic            s1_valid_ff;
   tod_type         s1_now_ff;
   logic            s2_valid_ff;
   ramp_sel_type    s2_sel_ff;
   ramp_sel_type    s2_sel_in;
   logic            out_valid_ff;
   rsp_payload_type out_payload_ff;
   rsp_payload_type out_payload_in;

   logic out_free;
   logic s2_free;
   logic s1_free;

   logic signed [12:0] raw_elapsed;

   // ---------------------------------------------------------------------
   // register writes, ramp length saturates at 59
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sunrise_hour_ff   <= '0;
         sunrise_minute_ff <= '0;
         sunset_hour_ff    <= '0;
         sunset_minute_ff  <= '0;
         ramp_minutes_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SUNRISE_HOUR:   sunrise_hour_ff   <= csr_wdata[4:0];
            CSR_SUNRISE_MINUTE: sunrise_minute_ff <= csr_wdata;
            CSR_SUNSET_HOUR:    sunset_hour_ff    <= csr_wdata[4:0];
            CSR_SUNSET_MINUTE:  sunset_minute_ff  <= csr_wdata;
            CSR_RAMP_MINUTES:   ramp_minutes_ff   <= (csr_wdata > RAMP_MAX) ? RAMP_MAX
                                                                            : csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.rise.h = sunrise_hour_ff;
   assign cfg.rise.m = sunrise_minute_ff;
   assign cfg.set.h  = sunset_hour_ff;
   assign cfg.set.m  = sunset_minute_ff;
   assign cfg.ramp   = ramp_minutes_ff;

   // ---------------------------------------------------------------------
   // flow control: a stage takes new data when it is empty or its item
   // moves on in the same cycle
   // ---------------------------------------------------------------------
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_free) begin
         s1_now_ff.h <= req_payload.now_hour;
         s1_now_ff.m <= req_payload.now_minute;
      end
   end

   // stage 2: window checks
   dpc_classify u_classify (
      .cfg (cfg),
      .now (s1_now_ff),
      .sel (s2_sel_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_sel_ff <= s2_sel_in;
      end
   end

   // stage 3: elapsed minutes, start vs ramp phase, clamp
   assign raw_elapsed = ramp_elapsed(s2_sel_ff.now, s2_sel_ff.start, s2_sel_ff.wraps);

   always_comb begin
      out_payload_in.phase           = s2_sel_ff.base_phase;
      out_payload_in.minutes_elapsed = '0;
      if (s2_sel_ff.ramp) begin
         if (raw_elapsed > 13'sd0) begin
            out_payload_in.phase = 3'(s2_sel_ff.base_phase + 3'd1);
         end
         if (raw_elapsed < 13'sd0) begin
            out_payload_in.minutes_elapsed = '0;
         end else if (raw_elapsed > 13'sd59) begin
            out_payload_in.minutes_elapsed = RAMP_MAX;
         end else begin
            out_payload_in.minutes_elapsed = raw_elapsed[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         out_payload_ff <= out_payload_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // stored ramp length never exceeds the saturation value
   a_ramp_saturated: assert property (@(posedge clock) disable iff (reset)
      ramp_minutes_ff <= RAMP_MAX)
      else $error("ramp length register above saturation value");

   // night and day carry no elapsed minutes, nor do the start phases
   a_no_elapsed_outside_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.phase == PHASE_NIGHT || rsp_payload.phase == PHASE_DAY ||
                    rsp_payload.phase == PHASE_RISE_START ||
                    rsp_payload.phase == PHASE_SET_START)
      |-> rsp_payload.minutes_elapsed == 6'd0)
      else $error("elapsed minutes set outside a running ramp");

   // a running ramp has at least one minute elapsed
   a_ramp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.phase == PHASE_RISE_RAMP ||
                    rsp_payload.phase == PHASE_SET_RAMP)
      |-> rsp_payload.minutes_elapsed != 6'd0)
      else $error("ramp phase with zero elapsed minutes");

   // a blocked middle stage keeps its item
   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(s2_sel_ff))
      else $error("window-check stage lost or changed a stalled item");

   // a blocked input stage keeps its item
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff && $stable(s1_now_ff))
      else $error("input stage lost or changed a stalled item");

endmodule

// File: tb/sv/daylight_phase_classifier_core_test.sv
// daylight_phase_classifier_core_test: self-checking bench for the daylight phase classifier
// depends on dpc_pkg and the daylight_phase_classifier_core rtl, nothing else

module daylight_phase_classifier_core_test;
   import dpc_pkg::*;

   // register indexes past the last register, writes there must change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_FIRST = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LAST  = 3'd7;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 42;
   localparam int REPORT_LIMIT    = 10;

   // time of day kept as plain integers so nothing wraps inside the predictor
   typedef struct packed {
      int hr;
      int mn;
   } hm_t;

   // one result still owed by the block, with the time that caused it
   typedef struct packed {
      req_payload_type asked;
      rsp_payload_type want;
   } phase_due_t;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_t;

   // directed row: register write (index, value) or time of day (hour, minute)
   typedef struct packed {
      row_kind_t       kind;
      logic [5:0]      arg_a;
      logic [5:0]      arg_b;
      logic            typed;
      rsp_payload_type want;
   } step_row_t;

   localparam int DIRECTED_ROWS = 40;

   step_row_t directed_rows [DIRECTED_ROWS] = '{
      // straight after reset every register is zero: only midnight is the sunrise start
      '{ROW_ITEM, 6'd0,  6'd0,  1'b1, '{PHASE_RISE_START, 6'd0}},
      '{ROW_ITEM, 6'd12, 6'd30, 1'b1, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd31, 6'd63, 1'b1, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd23, 6'd59, 1'b1, '{PHASE_NIGHT, 6'd0}},
      // ordinary day, 06:00 to 18:00 with half-hour ramps
      '{ROW_CSR,  CSR_SUNRISE_HOUR,   6'd6,  1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_SUNSET_HOUR,    6'd18, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_RAMP_MINUTES,   6'd30, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd6,  6'd0,  1'b1, '{PHASE_RISE_START, 6'd0}},
      '{ROW_ITEM, 6'd6,  6'd15, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd12, 6'd0,  1'b1, '{PHASE_DAY, 6'd0}},
      '{ROW_ITEM, 6'd18, 6'd0,  1'b1, '{PHASE_SET_START, 6'd0}},
      '{ROW_ITEM, 6'd18, 6'd30, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd18, 6'd31, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd3,  6'd0,  1'b1, '{PHASE_NIGHT, 6'd0}},
      // sunrise ramp across midnight, ramp write above the top saturates
      '{ROW_CSR,  CSR_SUNRISE_HOUR,   6'd23, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_SUNRISE_MINUTE, 6'd30, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_SUNSET_HOUR,    6'd12, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_RAMP_MINUTES,   6'd63, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd23, 6'd30, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd0,  6'd10, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd0,  6'd29, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd13, 6'd0,  1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd12, 6'd59, 1'b0, '{PHASE_NIGHT, 6'd0}},
      // writes to unused indexes, then night start pushed past midnight
      '{ROW_CSR,  CSR_UNUSED_FIRST,   6'd63, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_UNUSED_LAST,    6'd0,  1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_SUNRISE_HOUR,   6'd5,  1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_SUNSET_HOUR,    6'd23, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_SUNSET_MINUTE,  6'd59, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd23, 6'd59, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd0,  6'd30, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd0,  6'd59, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd4,  6'd59, 1'b0, '{PHASE_NIGHT, 6'd0}},
      // register values beyond a clock face, used as they stand
      '{ROW_CSR,  CSR_SUNRISE_HOUR,   6'd31, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_SUNRISE_MINUTE, 6'd63, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_CSR,  CSR_RAMP_MINUTES,   6'd0,  1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd31, 6'd63, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd0,  6'd0,  1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd30, 6'd5,  1'b0, '{PHASE_NIGHT, 6'd0}},
      // sunrise and sunset in the same hour
      '{ROW_CSR,  CSR_SUNRISE_HOUR,   6'd23, 1'b0, '{PHASE_NIGHT, 6'd0}},
      '{ROW_ITEM, 6'd23, 6'd59, 1'b0, '{PHASE_NIGHT, 6'd0}}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   req_payload_type                req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   rsp_payload_type                rsp_payload;
   logic                           csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_wdata = '0;

   // expectation for the item on the request port, when typed in by hand
   logic                           req_typed = 1'b0;
   rsp_payload_type                req_want = '0;

   // register copies as the block should hold them
   int cfg_rise_hr = 0;
   int cfg_rise_mn = 0;
   int cfg_set_hr  = 0;
   int cfg_set_mn  = 0;
   int cfg_ramp    = 0;

   phase_due_t expected_phases [$];
   int  times_sent     = 0;
   int  phases_checked = 0;
   int  settings_count = 0;
   int  mismatch_count = 0;
   int  rsp_seen       = 0;
   int  rsp_hold       = 0;
   bit  req_idle_on    = 1'b1;
   bit  rsp_idle_on    = 1'b1;

   daylight_phase_classifier_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // generous ceiling, far above the slowest legal run
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // add minutes to a time of day: one minute carry, one wrap at 24 hours
   function automatic hm_t hm_add(hm_t t, int mins);
      int carry;
      carry = 0;
      if (mins >= 60) begin
         carry = mins / 60;
         mins  = mins % 60;
      end
      t.mn = t.mn + mins;
      if (t.mn >= 60) begin
         t.mn  = t.mn - 60;
         carry = carry + 1;
      end
      t.hr = t.hr + carry;
      if (t.hr >= 24) begin
         t.hr = t.hr - 24;
      end
      return t;
   endfunction

   function automatic bit no_later(hm_t a, hm_t b);
      return (a.hr < b.hr) || ((a.hr == b.hr) && (a.mn <= b.mn));
   endfunction

   // half-open window from s up to e, no wrap
   function automatic bit in_span(hm_t t, hm_t s, hm_t e);
      if ((t.hr < s.hr) || (t.hr > e.hr)) begin
         return 1'b0;
      end
      if (s.hr == e.hr) begin
         return (t.mn >= s.mn) && (t.mn < e.mn);
      end
      if (t.hr == s.hr) begin
         return t.mn >= s.mn;
      end
      if (t.hr == e.hr) begin
         return t.mn < e.mn;
      end
      return 1'b1;
   endfunction

   // signed minutes since the ramp began, counted over midnight when it wraps
   function automatic int ramp_age(hm_t now, hm_t start, bit wraps);
      int to_mid;
      to_mid = (start.hr < 23) ? 23 - start.hr : 0;
      if (now == start) begin
         return 0;
      end
      if (!wraps) begin
         return no_later(start, now) ? (now.mn - start.mn) + (now.hr - start.hr) * 60 : 0;
      end
      if (no_later(now, start)) begin
         return now.hr * 60 + now.mn + (60 - start.mn) + 60 * to_mid;
      end
      return (now.hr - start.hr) * 60 + now.mn - start.mn;
   endfunction

   // start phase on the first minute, ramp phase after it, elapsed clamped
   function automatic rsp_payload_type ramp_result(hm_t now, hm_t start, bit wraps,
                                                   logic [2:0] base);
      int              raw;
      rsp_payload_type r;
      raw = ramp_age(now, start, wraps);
      r.minutes_elapsed = (raw < 0) ? 6'd0 : ((raw > 59) ? 6'd59 : 6'(raw));
      r.phase = (raw > 0) ? base + 3'd1 : base;
      return r;
   endfunction

   function automatic rsp_payload_type classify_time(req_payload_type p);
      hm_t             now;
      hm_t             rise;
      hm_t             rise_end;
      hm_t             dusk;
      hm_t             night_at;
      rsp_payload_type r;
      now.hr   = int'(p.now_hour);
      now.mn   = int'(p.now_minute);
      rise.hr  = cfg_rise_hr;
      rise.mn  = cfg_rise_mn;
      dusk.hr  = cfg_set_hr;
      dusk.mn  = cfg_set_mn;
      rise_end = hm_add(rise, cfg_ramp);
      night_at = hm_add(dusk, cfg_ramp + 1);
      r.phase  = PHASE_NIGHT;
      r.minutes_elapsed = 6'd0;
      // day window, taken as the complement of the night window when that one is plain
      if (no_later(night_at, rise)) begin
         if (!in_span(now, night_at, rise)) begin
            r.phase = PHASE_DAY;
         end
      end else if (in_span(now, rise, night_at)) begin
         r.phase = PHASE_DAY;
      end
      if (r.phase == PHASE_DAY) begin
         if (no_later(rise_end, rise)) begin
            if (!in_span(now, rise_end, rise)) begin
               r = ramp_result(now, rise, 1'b1, PHASE_RISE_START);
            end
         end else if (in_span(now, rise, rise_end)) begin
            r = ramp_result(now, rise, 1'b0, PHASE_RISE_START);
         end
      end
      if (r.phase == PHASE_DAY) begin
         if (no_later(night_at, dusk)) begin
            if (!in_span(now, night_at, dusk)) begin
               r = ramp_result(now, dusk, 1'b1, PHASE_SET_START);
            end
         end else if (in_span(now, dusk, night_at)) begin
            r = ramp_result(now, dusk, 1'b0, PHASE_SET_START);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // monitor: register copies, expectations in, results checked
   // ---------------------------------------------------------------------

   task automatic note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      phase_due_t due;
      if (reset) begin
         cfg_rise_hr = 0;
         cfg_rise_mn = 0;
         cfg_set_hr  = 0;
         cfg_set_mn  = 0;
         cfg_ramp    = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SUNRISE_HOUR:   cfg_rise_hr = int'(csr_wdata[4:0]);
               CSR_SUNRISE_MINUTE: cfg_rise_mn = int'(csr_wdata);
               CSR_SUNSET_HOUR:    cfg_set_hr  = int'(csr_wdata[4:0]);
               CSR_SUNSET_MINUTE:  cfg_set_mn  = int'(csr_wdata);
               CSR_RAMP_MINUTES:   cfg_ramp = (csr_wdata > RAMP_MAX) ? int'(RAMP_MAX)
                                                                     : int'(csr_wdata);
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            due.asked = req_payload;
            due.want  = req_typed ? req_want : classify_time(req_payload);
            expected_phases.push_back(due);
         end
         if (rsp_valid && rsp_ready) begin
            phases_checked++;
            if (expected_phases.size() == 0) begin
               note_failure($sformatf("result phase %0d elapsed %0d with no item outstanding",
                                      rsp_payload.phase, rsp_payload.minutes_elapsed));
            end else begin
               due = expected_phases.pop_front();
               if ((rsp_payload.phase !== due.want.phase) ||
                   (rsp_payload.minutes_elapsed !== due.want.minutes_elapsed)) begin
                  note_failure($sformatf(
                     "time %0d:%0d expected phase %0d elapsed %0d, got phase %0d elapsed %0d",
                     due.asked.now_hour, due.asked.now_minute, due.want.phase,
                     due.want.minutes_elapsed, rsp_payload.phase,
                     rsp_payload.minutes_elapsed));
               end
            end
         end
      end
   end

   // result side back-pressure: after each item taken, ready may be held low at random while idling is on
   always @(negedge clock) begin
      if (rsp_seen != phases_checked) begin
         rsp_seen = phases_checked;
         rsp_hold = rsp_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (rsp_hold != 0) begin
         rsp_ready = 1'b0;
         rsp_hold  = rsp_hold - 1;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   // offer one time of day, hold it until taken; returns at the next falling edge
   task automatic send_time(logic [4:0] hr, logic [5:0] mn, logic typed,
                            rsp_payload_type want);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload.now_hour   = hr;
      req_payload.now_minute = mn;
      req_typed = typed;
      req_want  = want;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      times_sent++;
      @(negedge clock);
   endtask

   // registers change only with the pipe empty
   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      req_valid = 1'b0;
      while (expected_phases.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_index    = idx;
      csr_wdata    = val;
      csr_write_en = 1'b1;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   initial begin
      int  row;
      int  ph;
      int  n;
      int  reg_i;
      int  sel;
      int  val;
      int  pick;
      int  total;
      int  spin;
      logic [4:0] hr;
      logic [5:0] mn;

      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed table
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (directed_rows[row].kind == ROW_CSR) begin
            csr_write(directed_rows[row].arg_a[CSR_INDEX_WIDTH-1:0], directed_rows[row].arg_b);
         end else begin
            send_time(directed_rows[row].arg_a[4:0], directed_rows[row].arg_b,
                      directed_rows[row].typed, directed_rows[row].want);
         end
      end

      // random phases, each with fresh registers and its own idling pattern
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         sel = $urandom_range(0, 7);
         for (reg_i = 0; reg_i < 5; reg_i++) begin
            if (sel == 0) begin
               // extremes: earliest sunrise, latest sunset, longest ramp
               val = (reg_i == CSR_SUNSET_HOUR) ? 23 :
                     ((reg_i == CSR_SUNSET_MINUTE) || (reg_i == CSR_RAMP_MINUTES)) ? 59 : 0;
            end else if (sel == 1) begin
               val = $urandom_range(0, 63);
            end else if ((reg_i == CSR_SUNRISE_HOUR) || (reg_i == CSR_SUNSET_HOUR)) begin
               val = $urandom_range(0, 23);
            end else if ((reg_i == CSR_RAMP_MINUTES) && (sel == 2)) begin
               val = $urandom_range(55, 63);
            end else if ((reg_i == CSR_RAMP_MINUTES) && (sel == 4)) begin
               val = 0;
            end else begin
               val = $urandom_range(0, 59);
            end
            csr_write(reg_i[CSR_INDEX_WIDTH-1:0], val[CSR_DATA_WIDTH-1:0]);
         end
         if (sel == 3) begin
            val = $urandom_range(0, 63);
            csr_write(CSR_INDEX_WIDTH'($urandom_range(CSR_UNUSED_FIRST, CSR_UNUSED_LAST)),
                      val[CSR_DATA_WIDTH-1:0]);
         end
         settings_count++;
         req_idle_on = (ph != 1) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (ph != 1) && ($urandom_range(0, 3) != 0);

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               // anything the fields can carry
               hr = 5'($urandom_range(0, 31));
               mn = 6'($urandom_range(0, 63));
            end else if (pick <= 4) begin
               // close to a ramp start, just before it up to just past its end
               total = (pick <= 2) ? cfg_rise_hr * 60 + cfg_rise_mn
                                   : cfg_set_hr * 60 + cfg_set_mn;
               total = total + 1440 + $urandom_range(0, cfg_ramp + 4) - 2;
               hr = 5'((total / 60) % 24);
               mn = 6'(total % 60);
            end else begin
               hr = 5'($urandom_range(0, 23));
               mn = 6'($urandom_range(0, 59));
            end
            send_time(hr, mn, 1'b0, '0);
         end
      end

      // drain, then allow the pipe depth once more
      req_valid = 1'b0;
      for (spin = 0; (spin < 1000) && (expected_phases.size() != 0); spin++) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      if (expected_phases.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", expected_phases.size()));
      end

      $display("sent %0d times of day over %0d random register settings plus directed rows",
               times_sent, settings_count);
      $display("compared %0d results, %0d failures", phases_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/dpc_pkg.sv
rtl/dpc_classify.sv
rtl/daylight_phase_classifier_core.sv
tb/sv/daylight_phase_classifier_core_test.sv
